### design/mme_pkg.sv
// Package for the matrix multiply engine: command/status types, config
// register indexes, reset values and the size clamp function. No dependencies.
`default_nettype none
package mme_pkg;

	localparam int unsigned MAX_DIM_DEF = 8;

	localparam int unsigned CFG_W   = 4;
	localparam int unsigned CIDX_W  = 2;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned PROD_W  = 64;
	localparam int unsigned ACC_W   = 67;
	localparam int unsigned FRAC_W  = 16;

	localparam logic [CIDX_W-1:0] CFG_ROWS_A    = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_INNER_DIM = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_COLS_B    = 2'd2;

	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	localparam logic [DATA_W-1:0] Q_MAX = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

	typedef struct packed {
		logic             wr_a;
		logic             wr_b;
		logic             issue;
		logic             first_k;
		logic             last_k;
		logic             last_elem;
		logic [IDX_W-1:0] r;
		logic [IDX_W-1:0] c;
		logic [IDX_W-1:0] k;
	} mme_cmd_t;

	typedef struct packed {
		logic pipe_busy;
	} mme_status_t;

	// clamp a size register to 1..maxd
	function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
		input logic [CFG_W-1:0] maxd);
		logic [CFG_W-1:0] res;
		if (v == '0) begin
			res = 4'd1;
		end else if (v > maxd) begin
			res = maxd;
		end else begin
			res = v;
		end
		return res;
	endfunction

endpackage
`default_nettype wire

### design/mme_ctrl.sv
// Controller of the matrix multiply engine: config registers, load decode and
// the row/column/inner index sequencer. Depends on mme_pkg.
`default_nettype none
module mme_ctrl import mme_pkg::*; #(
	parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              req_type,
	input  wire logic [IDX_W-1:0]  row,
	input  wire logic [IDX_W-1:0]  col,
	input  wire logic              final_load,
	input  wire logic              cfg_we,
	input  wire logic [CIDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]  cfg_wdata,
	input  wire mme_status_t       status,
	output logic                   busy,
	output mme_cmd_t               cmd
);

	localparam logic [CFG_W-1:0] MAXD = CFG_W'(MAX_DIM);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic             state_q;
	logic [CFG_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
	logic [IDX_W-1:0] r_q, c_q, k_q;
	logic [CFG_W-1:0] ra, kd, cb;
	logic             accept, a_ok, b_ok, k_last, c_last, r_last;

	assign ra = eff_dim(rows_a_q, MAXD);
	assign kd = eff_dim(inner_dim_q, MAXD);
	assign cb = eff_dim(cols_b_q, MAXD);

	assign busy   = (state_q == ST_RUN) || status.pipe_busy;
	assign accept = start && !busy;

	assign a_ok = ({1'b0, row} < ra) && ({1'b0, col} < kd);
	assign b_ok = ({1'b0, row} < kd) && ({1'b0, col} < cb);

	assign k_last = ({1'b0, k_q} == kd - 4'd1);
	assign c_last = ({1'b0, c_q} == cb - 4'd1);
	assign r_last = ({1'b0, r_q} == ra - 4'd1);

	always_comb begin
		cmd           = '0;
		cmd.wr_a      = accept && !req_type && a_ok;
		cmd.wr_b      = accept && req_type && b_ok;
		cmd.issue     = (state_q == ST_RUN);
		cmd.first_k   = (k_q == '0);
		cmd.last_k    = k_last;
		cmd.last_elem = k_last && c_last && r_last;
		cmd.r         = r_q;
		cmd.c         = c_q;
		cmd.k         = k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= CFG_RESET;
			inner_dim_q <= CFG_RESET;
			cols_b_q    <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ROWS_A:    rows_a_q    <= cfg_wdata;
				CFG_INNER_DIM: inner_dim_q <= cfg_wdata;
				CFG_COLS_B:    cols_b_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					r_q <= '0;
					c_q <= '0;
					k_q <= '0;
					if (accept && final_load) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (k_last) begin
						k_q <= '0;
						if (c_last) begin
							c_q <= '0;
							if (r_last) begin
								r_q     <= '0;
								state_q <= ST_IDLE;
							end else begin
								r_q <= r_q + 3'd1;
							end
						end else begin
							c_q <= c_q + 3'd1;
						end
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### design/mme_dp.sv
// Datapath of the matrix multiply engine: both matrix stores with valid bits,
// the multiply-accumulate pipeline and the Q16.16 saturation. Depends on mme_pkg.
`default_nettype none
module mme_dp import mme_pkg::*; #(
	parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire mme_cmd_t                 cmd,
	input  wire logic [IDX_W-1:0]         row,
	input  wire logic [IDX_W-1:0]         col,
	input  wire logic signed [DATA_W-1:0] value,
	output mme_status_t                   status,
	output logic                          out_valid,
	output logic [IDX_W-1:0]              out_row,
	output logic [IDX_W-1:0]              out_col,
	output logic signed [DATA_W-1:0]      out_value,
	output logic                          saturated,
	output logic                          last
);

	localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DATA_W-1:0] mem_a [DEPTH];
	logic [DATA_W-1:0] mem_b [DEPTH];
	logic [DEPTH-1:0]  va_q, vb_q;

	logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;

	logic [DATA_W-1:0]       rd_a_s1, rd_b_s1;
	logic                    rva_s1, rvb_s1;
	logic                    v_s1, v_s2, v_s3;
	logic                    first_s1, first_s2;
	logic                    lastk_s1, lastk_s2, lastk_s3;
	logic                    lastel_s1, lastel_s2, lastel_s3;
	logic [IDX_W-1:0]        r_s1, r_s2, r_s3, c_s1, c_s2, c_s3;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_s3;
	logic signed [DATA_W-1:0] opa, opb;
	logic [ACC_W-1-FRAC_W-DATA_W+1:0] hi;
	logic                     sat_w;

	logic                    out_valid_q, saturated_q, last_q;
	logic [IDX_W-1:0]        out_row_q, out_col_q;
	logic [DATA_W-1:0]       out_value_q;

	assign wr_addr   = AW'(7'(row) * 7'(MAX_DIM) + 7'(col));
	assign rd_addr_a = AW'(7'(cmd.r) * 7'(MAX_DIM) + 7'(cmd.k));
	assign rd_addr_b = AW'(7'(cmd.k) * 7'(MAX_DIM) + 7'(cmd.c));

	assign status.pipe_busy = v_s1 || v_s2 || v_s3;

	// stores
	always_ff @(posedge clk) begin
		if (cmd.wr_a) begin
			mem_a[wr_addr] <= value;
		end
		if (cmd.wr_b) begin
			mem_b[wr_addr] <= value;
		end
		rd_a_s1 <= mem_a[rd_addr_a];
		rd_b_s1 <= mem_b[rd_addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q   <= '0;
			vb_q   <= '0;
			rva_s1 <= 1'b0;
			rvb_s1 <= 1'b0;
		end else begin
			if (cmd.wr_a) begin
				va_q[wr_addr] <= 1'b1;
			end
			if (cmd.wr_b) begin
				vb_q[wr_addr] <= 1'b1;
			end
			rva_s1 <= va_q[rd_addr_a];
			rvb_s1 <= vb_q[rd_addr_b];
		end
	end

	// multiply-accumulate pipeline
	assign opa = rva_s1 ? signed'(rd_a_s1) : '0;
	assign opb = rvb_s1 ? signed'(rd_b_s1) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1        <= cmd.issue;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3 && lastk_s3;
		end
	end

	always_ff @(posedge clk) begin
		first_s1  <= cmd.first_k;
		lastk_s1  <= cmd.last_k;
		lastel_s1 <= cmd.last_elem;
		r_s1      <= cmd.r;
		c_s1      <= cmd.c;

		prod_s2   <= opa * opb;
		first_s2  <= first_s1;
		lastk_s2  <= lastk_s1;
		lastel_s2 <= lastel_s1;
		r_s2      <= r_s1;
		c_s2      <= c_s1;

		if (v_s2) begin
			acc_s3 <= first_s2 ? ACC_W'(prod_s2) : acc_s3 + ACC_W'(prod_s2);
		end
		lastk_s3  <= lastk_s2;
		lastel_s3 <= lastel_s2;
		r_s3      <= r_s2;
		c_s3      <= c_s2;

		out_row_q   <= r_s3;
		out_col_q   <= c_s3;
		last_q      <= lastel_s3;
		saturated_q <= sat_w;
		if (sat_w) begin
			out_value_q <= acc_s3[ACC_W-1] ? Q_MIN : Q_MAX;
		end else begin
			out_value_q <= acc_s3[FRAC_W+DATA_W-1:FRAC_W];
		end
	end

	// drop the fraction, clip to Q16.16
	assign hi    = acc_s3[ACC_W-1:FRAC_W+DATA_W-1];
	assign sat_w = !((&hi) || !(|hi));

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_value = signed'(out_value_q);
	assign saturated = saturated_q;
	assign last      = last_q;

`ifndef NO_ASSERTIONS
	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && saturated_q |-> (out_value_q == Q_MAX) || (out_value_q == Q_MIN))
		else $error("saturated word is not at a range limit");

	a_last_drained: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_q |-> !status.pipe_busy && !cmd.issue)
		else $error("work still in flight after the last word");

	a_no_load_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> !cmd.wr_a && !cmd.wr_b)
		else $error("store written during a multiply run");

	a_last_elem_ends_dot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue && cmd.last_elem |-> cmd.last_k)
		else $error("last element flagged before its inner sum ends");
`endif

endmodule
`default_nettype wire

### design/matrix_multiply_engine.sv
// Load: a start taken when not busy writes an in-range word, no result. A final
// load starts index issue over rows_a*cols_b*inner_dim triples (one store read
// pair per cycle). Words pass store read, multiply, accumulate, output registers,
// one per inner sum; busy drops in the cycle of the last word. Words cannot be held.
// Reset: async active low, sizes return to 8, both stores read as zero.
// Top level; instantiates mme_ctrl and mme_dp, depends on mme_pkg.
`default_nettype none
module matrix_multiply_engine import mme_pkg::*; #(
	parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic                     cfg_we,
	input  wire logic [CIDX_W-1:0]        cfg_idx,
	input  wire logic [CFG_W-1:0]         cfg_wdata,
	input  wire logic                     req_type,
	input  wire logic [IDX_W-1:0]         row,
	input  wire logic [IDX_W-1:0]         col,
	input  wire logic signed [DATA_W-1:0] value,
	input  wire logic                     final_load,
	output logic                          out_valid,
	output logic [IDX_W-1:0]              out_row,
	output logic [IDX_W-1:0]              out_col,
	output logic signed [DATA_W-1:0]      out_value,
	output logic                          saturated,
	output logic                          last
);

	mme_cmd_t    cmd;
	mme_status_t status;

	mme_ctrl #(
		.MAX_DIM(MAX_DIM)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req_type  (req_type),
		.row       (row),
		.col       (col),
		.final_load(final_load),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.status    (status),
		.busy      (busy),
		.cmd       (cmd)
	);

	mme_dp #(
		.MAX_DIM(MAX_DIM)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.row      (row),
		.col      (col),
		.value    (value),
		.status   (status),
		.out_valid(out_valid),
		.out_row  (out_row),
		.out_col  (out_col),
		.out_value(out_value),
		.saturated(saturated),
		.last     (last)
	);

endmodule
`default_nettype wire

### sim/testbench.sv
// Testbench for matrix_multiply_engine: loads A and B words, triggers products and checks
// every product word against a local fixed-point predictor. Depends on mme_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
	import mme_pkg::*;

	typedef enum logic {LOAD_A, LOAD_B} matrix_sel_t;

	typedef struct packed {
		matrix_sel_t      sel;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [31:0]      value;
		logic             fin;
	} load_word_t;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [31:0]      value;
		logic             sat;
		logic             last;
	} product_word_t;

	localparam int                 DIM       = 8;
	localparam logic [CIDX_W-1:0]  CFG_SPARE = 2'd3;
	localparam logic signed [66:0] Q_HI      = 67'sd2147483647;
	localparam logic signed [66:0] Q_LO      = -67'sd2147483648;
	localparam int                 SETTLE    = 16;
	localparam int                 PHASE_ITEMS = 83;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic                     cfg_we = 1'b0;
	logic [CIDX_W-1:0]        cfg_idx = '0;
	logic [CFG_W-1:0]         cfg_wdata = '0;
	logic                     req_type = 1'b0;
	logic [IDX_W-1:0]         row = '0;
	logic [IDX_W-1:0]         col = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     final_load = 1'b0;
	logic                     out_valid;
	logic [IDX_W-1:0]         out_row;
	logic [IDX_W-1:0]         out_col;
	logic signed [DATA_W-1:0] out_value;
	logic                     saturated;
	logic                     last;

	matrix_multiply_engine DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.req_type(req_type), .row(row), .col(col), .value(value), .final_load(final_load),
		.out_valid(out_valid), .out_row(out_row), .out_col(out_col),
		.out_value(out_value), .saturated(saturated), .last(last)
	);

	logic [31:0]     mat_a [0:DIM*DIM-1];
	logic [31:0]     mat_b [0:DIM*DIM-1];
	logic [CFG_W-1:0] size_rows = CFG_RESET;
	logic [CFG_W-1:0] size_inner = CFG_RESET;
	logic [CFG_W-1:0] size_cols = CFG_RESET;
	load_word_t      pending_loads[$];
	product_word_t   product_words[$];
	int              idle_pct = 28;
	int              items_done = 0;
	int              fail_count = 0;

	initial begin
		for (int i = 0; i < DIM*DIM; i++) begin
			mat_a[i] = '0;
			mat_b[i] = '0;
		end
	end

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("testbench: errors");
		$finish;
	end

	function automatic int clamp_dim(logic [CFG_W-1:0] v);
		if (v == '0) return 1;
		if (v > DIM) return DIM;
		return int'(v);
	endfunction

	function automatic bit in_range(matrix_sel_t sel, int r, int c);
		if (sel == LOAD_A) return r < clamp_dim(size_rows) && c < clamp_dim(size_inner);
		return r < clamp_dim(size_inner) && c < clamp_dim(size_cols);
	endfunction

	// apply one accepted load, then predict the product if it is the final one
	function automatic void accept_load(load_word_t w);
		int ra, kd, cb;
		logic signed [66:0] acc;
		logic signed [66:0] q;
		product_word_t p;
		ra = clamp_dim(size_rows);
		kd = clamp_dim(size_inner);
		cb = clamp_dim(size_cols);
		if (in_range(w.sel, w.row, w.col)) begin
			if (w.sel == LOAD_A) mat_a[w.row*DIM + w.col] = w.value;
			else mat_b[w.row*DIM + w.col] = w.value;
		end
		if (!w.fin) return;
		for (int r = 0; r < ra; r++) begin
			for (int c = 0; c < cb; c++) begin
				acc = '0;
				for (int k = 0; k < kd; k++)
					acc = acc + $signed(mat_a[r*DIM + k]) * $signed(mat_b[k*DIM + c]);
				q = acc >>> FRAC_W;
				p.row = r[IDX_W-1:0];
				p.col = c[IDX_W-1:0];
				p.sat = (q > Q_HI) || (q < Q_LO);
				p.value = (q > Q_HI) ? Q_MAX : (q < Q_LO) ? Q_MIN : q[31:0];
				p.last = (r == ra - 1) && (c == cb - 1);
				product_words.push_back(p);
			end
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : drive_loads
		load_word_t w;
		if (!arst_n) begin
			start <= 1'b0;
			req_type <= 1'b0;
			row <= '0;
			col <= '0;
			value <= '0;
			final_load <= 1'b0;
		end else begin
			if (start && !busy) begin
				w.sel = matrix_sel_t'(req_type);
				w.row = row;
				w.col = col;
				w.value = value;
				w.fin = final_load;
				accept_load(w);
			end
			if (!start || !busy) begin
				if (pending_loads.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					w = pending_loads.pop_front();
					start <= 1'b1;
					req_type <= w.sel;
					row <= w.row;
					col <= w.col;
					value <= w.value;
					final_load <= w.fin;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : watch_products
		product_word_t want;
		if (arst_n && out_valid) begin
			if (product_words.size() == 0) begin
				$error("unexpected product word at row %0d col %0d", out_row, out_col);
				fail_count++;
			end else begin
				want = product_words.pop_front();
				check_field("out_row", want.row, out_row);
				check_field("out_col", want.col, out_col);
				check_field("out_value", want.value, out_value);
				check_field("saturated", want.sat, saturated);
				check_field("last", want.last, last);
			end
		end
	end

	task automatic push_load(matrix_sel_t sel, int r, int c, logic [31:0] v, bit fin);
		load_word_t w;
		w.sel = sel;
		w.row = r[IDX_W-1:0];
		w.col = c[IDX_W-1:0];
		w.value = v;
		w.fin = fin;
		items_done++;
		pending_loads.push_back(w);
	endtask

	// hold until the block is quiet and every product word has arrived
	task automatic drain();
		do @(negedge clk);
		while (pending_loads.size() != 0 || start || busy || product_words.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_size(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_ROWS_A:    size_rows = v;
			CFG_INNER_DIM: size_inner = v;
			CFG_COLS_B:    size_cols = v;
			default: ;
		endcase
	endtask

	function automatic logic [CFG_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return CFG_W'($urandom_range(8, 15));
			default: return CFG_W'($urandom_range(1, 4));
		endcase
	endfunction

	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 3))
			0: return v;
			1: return {{12{v[19]}}, v[19:0]};
			2: begin
				case (v[1:0])
					2'd0: return Q_MAX;
					2'd1: return Q_MIN;
					2'd2: return '0;
					default: return '1;
				endcase
			end
			default: begin
				v = $urandom_range(0, 32'h3ffff);
				return $urandom_range(0, 1) ? -v : v;
			end
		endcase
	endfunction

	task automatic add_random_load(bit fin);
		matrix_sel_t sel;
		int r, c;
		sel = matrix_sel_t'($urandom_range(0, 1));
		if (sel == LOAD_A) begin
			r = $urandom_range(0, clamp_dim(size_rows) - 1);
			c = $urandom_range(0, clamp_dim(size_inner) - 1);
		end else begin
			r = $urandom_range(0, clamp_dim(size_inner) - 1);
			c = $urandom_range(0, clamp_dim(size_cols) - 1);
		end
		push_load(sel, r, c, pick_value(), fin);
	endtask

	initial begin : stimulus
		int n;
		int phase_goal;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// saturation both ways; an ignored load still starts the product
		write_size(CFG_ROWS_A, 4'd1);
		write_size(CFG_INNER_DIM, 4'd2);
		write_size(CFG_COLS_B, 4'd2);
		push_load(LOAD_A, 0, 0, Q_MAX, 1'b0);
		push_load(LOAD_A, 0, 1, Q_MIN, 1'b0);
		push_load(LOAD_B, 0, 0, Q_MAX, 1'b0);
		push_load(LOAD_B, 0, 1, Q_MIN, 1'b0);
		push_load(LOAD_B, 1, 0, 32'h0000_0001, 1'b0);
		push_load(LOAD_B, 1, 1, 32'hffff_ffff, 1'b0);
		push_load(LOAD_A, 5, 6, 32'h1234_5678, 1'b1);
		drain();

		// zero and oversized sizes clamp; spare index is ignored; unloaded zeros
		write_size(CFG_SPARE, 4'd15);
		write_size(CFG_ROWS_A, 4'd0);
		write_size(CFG_INNER_DIM, 4'd15);
		write_size(CFG_COLS_B, 4'd9);
		push_load(LOAD_B, 7, 7, 32'h0001_0000, 1'b0);
		push_load(LOAD_B, 7, 0, 32'h0000_0001, 1'b0);
		push_load(LOAD_A, 0, 7, 32'hffff_ffff, 1'b1);
		drain();

		write_size(CFG_ROWS_A, 4'd8);
		write_size(CFG_INNER_DIM, 4'd1);
		write_size(CFG_COLS_B, 4'd1);
		push_load(LOAD_A, 7, 0, Q_MIN, 1'b0);
		push_load(LOAD_B, 0, 0, Q_MIN, 1'b1);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 28 : (phase == 1) ? 59 : 0;
			phase_goal = items_done + PHASE_ITEMS;
			n = 0;
			while (items_done < phase_goal) begin
				if (n == 0 || $urandom_range(0, 2) == 0) begin
					drain();
					write_size(CFG_ROWS_A, pick_size());
					write_size(CFG_INNER_DIM, pick_size());
					write_size(CFG_COLS_B, pick_size());
				end
				n++;
				if ($urandom_range(0, 4) != 0) begin
					repeat ($urandom_range(0, 5)) add_random_load(1'b0);
					if ($urandom_range(0, 3) == 0)
						push_load(matrix_sel_t'($urandom_range(0, 1)), $urandom_range(0, 7),
							$urandom_range(0, 7), pick_value(), 1'b0);
					add_random_load(1'b1);
				end else begin
					// noise: arbitrary indexes, maybe no trigger
					repeat ($urandom_range(1, 4))
						push_load(matrix_sel_t'($urandom_range(0, 1)), $urandom_range(0, 7),
							$urandom_range(0, 7), pick_value(), 1'b0);
					if ($urandom_range(0, 1))
						push_load(matrix_sel_t'($urandom_range(0, 1)), $urandom_range(0, 7),
							$urandom_range(0, 7), pick_value(), 1'b1);
				end
			end
			drain();
		end

		if (fail_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
